[hw/rtl/dcp_pkg.sv]
package dcp_pkg;

  // Pipeline depth of the iterative units.
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 31;

  // Configuration register indexes.
  localparam logic [1:0] REG_REST  = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_RATIO = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [30:0] REST_RESET  = 31'd65536;
  localparam logic [16:0] GAIN_RESET  = 17'd65536;
  localparam logic [15:0] RATIO_RESET = 16'd512;

  // Positions of both particles, raw Q16.16 words.
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
  } pos_t;

  // Positions plus the separation split into sign and magnitude.
  typedef struct packed {
    pos_t        pos;
    logic        negx;
    logic        negy;
    logic [32:0] mx;
    logic [32:0] my;
  } diff_t;

  // One slot of the square root pipeline.
  typedef struct packed {
    diff_t       df;
    logic [64:0] sq;
    logic [35:0] rem;
    logic [32:0] root;
  } sqrt_t;

  // Correction control after the length is known.
  typedef struct packed {
    diff_t       df;
    logic [32:0] len;
    logic [33:0] hmag;
    logic        hneg;
    logic        fix;
    logic        link;
  } corr_t;

  // One slot of the two-lane divider pipeline.
  typedef struct packed {
    corr_t       c;
    logic [33:0] remx;
    logic [33:0] remy;
    logic [30:0] qx;
    logic [30:0] qy;
  } div_t;

  // Products of the correction magnitude and the unit axis.
  typedef struct packed {
    pos_t        pos;
    logic        fix;
    logic        link;
    logic        negx;
    logic        negy;
    logic        hneg;
    logic [64:0] px;
    logic [64:0] py;
  } prod_t;

endpackage

[hw/rtl/distance_constraint_projection_unit.sv]
// Channel  Dir  Payload                                              Handshake
// in_      in   tdata: first_x, first_y, second_x, second_y          tvalid/tready
// out_     out  tdata: new_first_x, new_first_y, new_second_x,       tvalid/tready
//                      new_second_y; tuser: link_broken
// cfg_     in   index 0 rest_length, 1 stiffness_gain, 2 break_ratio valid/ready
//
// One request enters per cycle while the output register is free or being taken;
// each request passes through the 33-step square root and the 31-step divider,
// each resolving one bit per pipeline stage.
// rst_n (synchronous, active low) empties the pipeline, clears the broken flag
// and loads the register reset values.
// When the output register is full and not taken, the whole pipeline holds.
module distance_constraint_projection_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // first_x, first_y, second_x, second_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // new_first_x, new_first_y, new_second_x, new_second_y
  output logic [0:0]   out_tuser,  // link_broken
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [30:0] rest_r;
  logic [16:0] gain_r;
  logic [15:0] ratio_r;
  logic        broken_r;
  logic        broken_nxt;
  logic        adv;

  dcp_pkg::diff_t df_r;
  dcp_pkg::diff_t df_nxt;
  logic           df_v_r;

  dcp_pkg::sqrt_t sq_r   [0:dcp_pkg::SQRT_STEPS];
  logic           sq_v_r [0:dcp_pkg::SQRT_STEPS];

  dcp_pkg::corr_t dv_r_init_c;

  dcp_pkg::div_t  dv_r   [0:dcp_pkg::DIV_STEPS];
  logic           dv_v_r [0:dcp_pkg::DIV_STEPS];

  dcp_pkg::prod_t pr_r;
  logic           pr_v_r;

  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic         out_link_r;
  logic [127:0] out_data_nxt;

  // Saturate a 37-bit two's complement value to 32 bits.
  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] res;
    if (v[36] == 1'b0 && v[35:31] != 5'b00000) begin
      res = 32'h7FFF_FFFF;
    end else if (v[36] == 1'b1 && v[35:31] != 5'b11111) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // The whole pipeline moves while the output slot is free or being taken.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= dcp_pkg::REST_RESET;
      gain_r  <= dcp_pkg::GAIN_RESET;
      ratio_r <= dcp_pkg::RATIO_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcp_pkg::REG_REST:  rest_r  <= cfg_data[30:0];
        dcp_pkg::REG_GAIN:  gain_r  <= cfg_data[16:0];
        dcp_pkg::REG_RATIO: ratio_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage one: separation per axis as sign and magnitude.
  always_comb begin
    logic [32:0] dx;
    logic [32:0] dy;
    df_nxt.pos.ax = in_tdata[31:0];
    df_nxt.pos.ay = in_tdata[63:32];
    df_nxt.pos.bx = in_tdata[95:64];
    df_nxt.pos.by = in_tdata[127:96];
    dx = {in_tdata[31], in_tdata[31:0]} - {in_tdata[95], in_tdata[95:64]};
    dy = {in_tdata[63], in_tdata[63:32]} - {in_tdata[127], in_tdata[127:96]};
    df_nxt.negx = dx[32];
    df_nxt.negy = dy[32];
    df_nxt.mx   = dx[32] ? (33'd0 - dx) : dx;
    df_nxt.my   = dy[32] ? (33'd0 - dy) : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      df_v_r <= 1'b0;
    end else if (adv) begin
      df_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df_r <= df_nxt;
    end
  end

  // Stage two: squared length, exact in 65 bits.
  always_ff @(posedge clk) begin
    logic [65:0] sx;
    logic [65:0] sy;
    if (adv) begin
      sx            = df_r.mx * df_r.mx;
      sy            = df_r.my * df_r.my;
      sq_r[0].df   <= df_r;
      sq_r[0].sq   <= sx[64:0] + sy[64:0];
      sq_r[0].rem  <= 36'd0;
      sq_r[0].root <= 33'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= df_v_r;
    end
  end

  // Square root, one result bit per stage from the top pair of bits down.
  for (genvar k = 0; k < dcp_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam int Bit = dcp_pkg::SQRT_STEPS - 1 - k;
    logic [65:0] sq_ext;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    assign sq_ext = {1'b0, sq_r[k].sq};
    assign rem_sh = {sq_r[k].rem[33:0], sq_ext[2*Bit+1 -: 2]};
    assign trial  = {1'b0, sq_r[k].root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1].df   <= sq_r[k].df;
        sq_r[k+1].sq   <= sq_r[k].sq;
        sq_r[k+1].rem  <= ge ? (rem_sh - trial) : rem_sh;
        sq_r[k+1].root <= {sq_r[k].root[31:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
  end

  // Break test, length error and scaled correction magnitude.
  always_comb begin
    logic [32:0] len;
    logic [40:0] len_sh;
    logic [46:0] limit;
    logic        brk;
    logic [33:0] err;
    logic [33:0] err_mag;
    logic [50:0] hprod;
    len        = sq_r[dcp_pkg::SQRT_STEPS].root;
    len_sh     = {len, 8'd0};
    limit      = ratio_r * rest_r;
    brk        = {6'd0, len_sh} > limit;
    err        = {1'b0, len} - {3'd0, rest_r};
    err_mag    = err[33] ? (34'd0 - err) : err;
    hprod      = gain_r * err_mag;
    broken_nxt = broken_r | brk;
    dv_r_init_c.df   = sq_r[dcp_pkg::SQRT_STEPS].df;
    dv_r_init_c.len  = len;
    dv_r_init_c.hmag = hprod[50:17];
    dv_r_init_c.hneg = err[33];
    dv_r_init_c.fix  = !brk && (len != 33'd0);
    dv_r_init_c.link = broken_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      broken_r <= 1'b0;
    end else if (adv && sq_v_r[dcp_pkg::SQRT_STEPS]) begin
      broken_r <= broken_nxt;
    end
  end

  // The quotient stays below 2^31, so the divider starts from the magnitude halved.
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].c    <= dv_r_init_c;
      dv_r[0].remx <= {2'd0, dv_r_init_c.df.mx[32:1]};
      dv_r[0].remy <= {2'd0, dv_r_init_c.df.my[32:1]};
      dv_r[0].qx   <= 31'd0;
      dv_r[0].qy   <= 31'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[dcp_pkg::SQRT_STEPS];
    end
  end

  // Unit axis by restoring division, one quotient bit per stage in each lane.
  for (genvar j = 0; j < dcp_pkg::DIV_STEPS; j++) begin : g_div
    logic        bx_in;
    logic        by_in;
    logic [33:0] rx_sh;
    logic [33:0] ry_sh;
    logic [33:0] dvs;
    logic        gex;
    logic        gey;

    assign bx_in = (j == 0) ? dv_r[j].c.df.mx[0] : 1'b0;
    assign by_in = (j == 0) ? dv_r[j].c.df.my[0] : 1'b0;
    assign rx_sh = {dv_r[j].remx[32:0], bx_in};
    assign ry_sh = {dv_r[j].remy[32:0], by_in};
    assign dvs   = {1'b0, dv_r[j].c.len};
    assign gex   = rx_sh >= dvs;
    assign gey   = ry_sh >= dvs;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1].c    <= dv_r[j].c;
        dv_r[j+1].remx <= gex ? (rx_sh - dvs) : rx_sh;
        dv_r[j+1].remy <= gey ? (ry_sh - dvs) : ry_sh;
        dv_r[j+1].qx   <= {dv_r[j].qx[29:0], gex};
        dv_r[j+1].qy   <= {dv_r[j].qy[29:0], gey};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end
  end

  // Correction magnitude times the unit axis.
  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r.pos  <= dv_r[dcp_pkg::DIV_STEPS].c.df.pos;
      pr_r.fix  <= dv_r[dcp_pkg::DIV_STEPS].c.fix;
      pr_r.link <= dv_r[dcp_pkg::DIV_STEPS].c.link;
      pr_r.negx <= dv_r[dcp_pkg::DIV_STEPS].c.df.negx;
      pr_r.negy <= dv_r[dcp_pkg::DIV_STEPS].c.df.negy;
      pr_r.hneg <= dv_r[dcp_pkg::DIV_STEPS].c.hneg;
      pr_r.px   <= dv_r[dcp_pkg::DIV_STEPS].c.hmag * dv_r[dcp_pkg::DIV_STEPS].qx;
      pr_r.py   <= dv_r[dcp_pkg::DIV_STEPS].c.hmag * dv_r[dcp_pkg::DIV_STEPS].qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (adv) begin
      pr_v_r <= dv_v_r[dcp_pkg::DIV_STEPS];
    end
  end

  // Apply the signed correction and saturate the new positions.
  always_comb begin
    logic [36:0] cmx;
    logic [36:0] cmy;
    logic [36:0] cx;
    logic [36:0] cy;
    cmx = {2'd0, pr_r.px[64:30]};
    cmy = {2'd0, pr_r.py[64:30]};
    cx  = 37'd0;
    cy  = 37'd0;
    if (pr_r.fix) begin
      cx = (pr_r.hneg ^ pr_r.negx) ? (37'd0 - cmx) : cmx;
      cy = (pr_r.hneg ^ pr_r.negy) ? (37'd0 - cmy) : cmy;
    end
    out_data_nxt[31:0]   = sat32({{5{pr_r.pos.ax[31]}}, pr_r.pos.ax} - cx);
    out_data_nxt[63:32]  = sat32({{5{pr_r.pos.ay[31]}}, pr_r.pos.ay} - cy);
    out_data_nxt[95:64]  = sat32({{5{pr_r.pos.bx[31]}}, pr_r.pos.bx} + cx);
    out_data_nxt[127:96] = sat32({{5{pr_r.pos.by[31]}}, pr_r.pos.by} + cy);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_link_r <= pr_r.link;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_link_r;

  // The broken flag never clears outside reset.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(broken_r))
    else $error("broken flag cleared");

  // A result reporting a broken link was preceded by setting the flag.
  a_link_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_link_r) |-> broken_r)
    else $error("result reports a break the flag never saw");

  // The root leaving the square root pipeline never overshoots.
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[dcp_pkg::SQRT_STEPS] |->
      ({33'd0, sq_r[dcp_pkg::SQRT_STEPS].root} * {33'd0, sq_r[dcp_pkg::SQRT_STEPS].root})
        <= {1'b0, sq_r[dcp_pkg::SQRT_STEPS].sq})
    else $error("square root too large");

  // A unit axis component never exceeds one.
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[dcp_pkg::DIV_STEPS] && dv_r[dcp_pkg::DIV_STEPS].c.fix) |->
      (dv_r[dcp_pkg::DIV_STEPS].qx <= 31'h4000_0000 &&
       dv_r[dcp_pkg::DIV_STEPS].qy <= 31'h4000_0000))
    else $error("unit axis above one");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  // Index that maps to no register; a write to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // first_x, first_y, second_x, second_y
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // new_first_x, new_first_y, new_second_x, new_second_y
  logic [0:0]   out_tuser;  // link_broken
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  typedef struct {
    logic [127:0] pos;
    logic         broken;
  } projection_t;

  // Local copy of the block's registers and sticky flag.
  logic [30:0] mdl_rest;
  logic [16:0] mdl_gain;
  logic [15:0] mdl_ratio;
  logic        mdl_broken;

  projection_t pending_q[$];
  int          errors;
  bit          gaps_on;
  bit          holdoff_req;
  int          idle_cycles;

  distance_constraint_projection_unit dut (.*);

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Correction of one axis, signed Q16.16.
  function automatic longint axis_shift(logic [63:0] hmag, bit hneg, longint d,
                                        logic [63:0] len);
    logic [63:0] dm;
    logic [63:0] u;
    logic [63:0] cm;
    dm = (d < 0) ? 64'(-d) : 64'(d);
    u  = (dm << 30) / len;
    cm = (hmag * u) >> 30;
    return (hneg != (d < 0)) ? -longint'(cm) : longint'(cm);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Projects one particle pair and updates the sticky flag.
  function automatic projection_t project_pair(logic [127:0] pos);
    projection_t r;
    longint ax, ay, bx, by, dx, dy, cx, cy, err;
    logic [65:0] mx, my, sq;
    logic [67:0] rem, root, trial;
    logic [63:0] len, limit, hmag, emag;
    ax = longint'($signed(pos[31:0]));
    ay = longint'($signed(pos[63:32]));
    bx = longint'($signed(pos[95:64]));
    by = longint'($signed(pos[127:96]));
    dx = ax - bx;
    dy = ay - by;
    mx = (dx < 0) ? 66'(-dx) : 66'(dx);
    my = (dy < 0) ? 66'(-dy) : 66'(dy);
    sq = mx * mx + my * my;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'((sq >> (2 * i)) & 66'd3);
      trial = (root << 2) | 68'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 68'd1;
      end
    end
    len   = root[63:0];
    limit = 64'(mdl_ratio) * 64'(mdl_rest);
    cx = 0;
    cy = 0;
    if ((len << 8) > limit) begin
      mdl_broken = 1'b1;
    end else if (len != 0) begin
      err  = longint'(len) - longint'(mdl_rest);
      emag = (err < 0) ? 64'(-err) : 64'(err);
      hmag = (64'(mdl_gain) * emag) >> 17;
      cx = axis_shift(hmag, err < 0, dx, len);
      cy = axis_shift(hmag, err < 0, dy, len);
    end
    r.pos    = {clamp32(by + cy), clamp32(bx + cx), clamp32(ay - cy), clamp32(ax - cx)};
    r.broken = mdl_broken;
    return r;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one pair; the expectation is queued on acceptance.
  task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                           logic [31:0] by);
    repeat (gap_cycles()) @(negedge clk);
    in_tdata  = {by, bx, ay, ax};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(project_pair(in_tdata));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Random pair: mostly separations of random scale, some full range, some at the rest length, some coincident.
  task automatic send_random_pair();
    logic [31:0] ax, ay, ddx, ddy;
    int mode;
    ax = $urandom;
    ay = $urandom;
    mode = $urandom_range(0, 9);
    ddx = $signed($urandom) >>> $urandom_range(0, 31);
    ddy = $signed($urandom) >>> $urandom_range(0, 31);
    if (mode == 0) send_pair(ax, ay, $urandom, $urandom);
    else if (mode == 1) send_pair(ax, ay, ax, ay);
    else if (mode == 2) send_pair(ax, ay, ax - {1'b0, mdl_rest}, ay);
    else send_pair(ax, ay, ax - ddx, ay - ddy);
  endtask

  // Waits until every queued result has come back.
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dcp_pkg::REG_REST:  mdl_rest  = data[30:0];
      dcp_pkg::REG_GAIN:  mdl_gain  = data[16:0];
      dcp_pkg::REG_RATIO: mdl_ratio = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(logic [31:0] rest, logic [31:0] gain, logic [31:0] ratio);
    drain();
    write_reg(dcp_pkg::REG_REST, rest);
    write_reg(dcp_pkg::REG_GAIN, gain);
    write_reg(dcp_pkg::REG_RATIO, ratio);
  endtask

  // Reset values: zero length, inside and exactly at the limit, then a break.
  task automatic test_reset_values();
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_pair(32'h00018000, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h00008000, 32'h0, 32'h0);
    send_pair(32'h00020000, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'hfffe0000);
    send_pair(32'h00010000, 32'h00010000, 32'hffff0000, 32'hffff0000);
    send_pair(32'h00000001, 32'h0, 32'h0, 32'h0);
    send_pair(32'h00020001, 32'h0, 32'h0, 32'h0);
    send_pair(32'h00008000, 32'h0, 32'h0, 32'h0);
  endtask

  // Register extremes, masking of high bits and the unused index.
  task automatic test_register_extremes();
    set_all(32'hffffffff, 32'hfffe0000, 32'hffffffff);
    write_reg(REG_UNUSED, 32'h0);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_pair(32'h7fffffff, 32'h0, 32'h7ffffff0, 32'h0);
    send_pair(32'h80000000, 32'h80000000, 32'h80000001, 32'h80000000);
    set_all(32'h7fffffff, 32'h0001ffff, 32'h0000ffff);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_pair(32'h00000100, 32'h0, 32'h0, 32'h0);
    set_all(32'h0, 32'h00010000, 32'h0000ffff);
    send_pair(32'h00000001, 32'h0, 32'h0, 32'h0);
    send_pair(32'h12345678, 32'h0, 32'h12345678, 32'h0);
    set_all(32'h00010000, 32'h00010000, 32'h0);
    send_pair(32'h00000001, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  // Random items over several register settings.
  task automatic test_random_settings();
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: set_all(32'h00010000, 32'h00010000, 32'd512);
        1: set_all(32'h7fffffff, 32'h0, 32'hffff);
        2: set_all(32'h0, 32'h0001ffff, 32'hffff);
        3: set_all(32'h7fffffff, 32'h0001ffff, 32'hffff);
        default: set_all($urandom, $urandom_range(0, 131071), $urandom_range(256, 65535));
      endcase
      gaps_on = (s != 2);
      for (int i = 0; i < 140; i++) send_random_pair();
    end
    gaps_on = 1'b1;
  endtask

  // The receiver holds off while the sender keeps offering pairs.
  task automatic test_backpressure();
    set_all($urandom, $urandom_range(0, 65536), 32'hffff);
    gaps_on = 1'b0;
    holdoff_req = 1'b1;
    for (int i = 0; i < 150; i++) send_random_pair();
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  initial begin
    int hold;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else begin
        hold = gap_cycles();
        out_tready = (hold == 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h broken %b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (out_tdata[32 * f +: 32] !== want.pos[32 * f +: 32]) begin
            $display("%0t: position word %0d expected %h actual %h", $time, f,
                     want.pos[32 * f +: 32], out_tdata[32 * f +: 32]);
            errors++;
          end
        end
        if (out_tuser[0] !== want.broken) begin
          $display("%0t: link_broken expected %b actual %b", $time, want.broken,
                   out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input, output or configuration channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("** distance_constraint_projection_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    gaps_on     = 1'b1;
    holdoff_req = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = dcp_pkg::REG_REST;
    cfg_data    = '0;
    mdl_rest    = dcp_pkg::REST_RESET;
    mdl_gain    = dcp_pkg::GAIN_RESET;
    mdl_ratio   = dcp_pkg::RATIO_RESET;
    mdl_broken  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("** distance_constraint_projection_unit: PASSED **");
    end else begin
      $display("** distance_constraint_projection_unit: FAILED **");
    end
    $finish;
  end

endmodule
